// ===== design/acm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package acm_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int ALPHABET   = 256;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int SYM_W      = $clog2(ALPHABET);
  localparam int GOTO_DEPTH = MAX_NODES * ALPHABET;
  localparam int GOTO_AW    = NODE_W + SYM_W;
  localparam int GOTO_W     = NODE_W + 1;
  localparam int TOTAL_W    = 32;
  localparam int HERE_W     = 10;
  localparam int HERE_MAX   = 1023;

  typedef enum logic [2:0] {
    K_PAT_BYTE = 3'd0,
    K_PAT_END  = 3'd1,
    K_BUILD    = 3'd2,
    K_TEXT     = 3'd3,
    K_NEW_TEXT = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_AFTER_BUILD  = 2'd2,
    ST_BEFORE_BUILD = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_INS_CHK,
    S_ROOT_RD,
    S_ROOT_CHK,
    S_POP,
    S_POP_W,
    S_FAIL_W,
    S_CH_RD,
    S_CH_CHK,
    S_S_CHK,
    S_SF_W,
    S_T_GCHK,
    S_T_FW,
    S_T_CHAIN,
    S_T_CW,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               we;
    logic [GOTO_AW-1:0] waddr;
    logic [GOTO_W-1:0]  wdata;
    logic [GOTO_AW-1:0] raddr;
  } goto_req_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [NODE_W-1:0] wdata;
    logic [NODE_W-1:0] raddr;
  } node_req_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic              wdata;
    logic [NODE_W-1:0] raddr;
  } flag_req_t;

endpackage
`default_nettype wire

// ===== design/acm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface acm_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] byte_value;

  modport source (output valid, output kind, output byte_value, input ready);
  modport sink (input valid, input kind, input byte_value, output ready);
endinterface

interface acm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [9:0]  matches_here;
  logic [31:0] match_total;
  logic [9:0]  current_node;

  modport source (output valid, output status, output matches_here, output match_total,
                  output current_node, input ready);
  modport sink (input valid, input status, input matches_here, input match_total,
                input current_node, output ready);
endinterface
`default_nettype wire

// ===== design/acm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module acm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/acm_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module acm_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  acm_req_if.sink                         req_i,
  acm_rsp_if.source                       rsp_o,
  output      acm_pkg::goto_req_t         goto_req_o,
  input  wire logic [acm_pkg::GOTO_W-1:0] goto_rd_i,
  output      acm_pkg::node_req_t         fail_req_o,
  input  wire logic [acm_pkg::NODE_W-1:0] fail_rd_i,
  output      acm_pkg::flag_req_t         final_req_o,
  input  wire logic                       final_rd_i,
  output      acm_pkg::node_req_t         queue_req_o,
  input  wire logic [acm_pkg::NODE_W-1:0] queue_rd_i
);

  acm_pkg::state_e state_q, state_d;

  logic [acm_pkg::GOTO_AW-1:0] clr_q, clr_d;
  logic [2:0]                  kind_q, kind_d;
  logic [7:0]                  sym_q, sym_d;
  logic [acm_pkg::CNT_W-1:0]   used_q, used_d;
  logic [acm_pkg::NODE_W-1:0]  insert_q, insert_d;
  logic [acm_pkg::NODE_W-1:0]  search_q, search_d;
  logic [acm_pkg::TOTAL_W-1:0] total_q, total_d;
  logic                        built_q, built_d;
  logic [acm_pkg::SYM_W-1:0]   c_q, c_d;
  logic [acm_pkg::CNT_W-1:0]   head_q, head_d;
  logic [acm_pkg::CNT_W-1:0]   tail_q, tail_d;
  logic [acm_pkg::NODE_W-1:0]  node_q, node_d;
  logic [acm_pkg::NODE_W-1:0]  fnode_q, fnode_d;
  logic [acm_pkg::NODE_W-1:0]  s_q, s_d;
  logic [acm_pkg::NODE_W-1:0]  child_q, child_d;
  logic [acm_pkg::CNT_W-1:0]   guard_q, guard_d;
  logic [acm_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]                  status_q, status_d;

  logic                        out_valid_q;
  logic [1:0]                  out_status_q;
  logic [acm_pkg::HERE_W-1:0]  out_here_q;
  logic [acm_pkg::TOTAL_W-1:0] out_total_q;
  logic [9:0]                  out_node_q;

  logic                        accept;
  logic                        load;
  logic                        in_alpha;
  logic                        g_valid;
  logic [acm_pkg::NODE_W-1:0]  g_node;
  logic                        guard_max;
  logic                        c_last;
  logic                        clr_low;
  logic [acm_pkg::SYM_W-1:0]   sym_slot;
  logic [acm_pkg::TOTAL_W:0]   sum;

  assign accept    = req_i.valid && req_i.ready;
  assign load      = (state_q == acm_pkg::S_DONE) && (!out_valid_q || rsp_o.ready);
  assign in_alpha  = ({1'b0, sym_q} < 9'(acm_pkg::ALPHABET));
  assign g_valid   = goto_rd_i[acm_pkg::NODE_W];
  assign g_node    = goto_rd_i[acm_pkg::NODE_W-1:0];
  assign guard_max = (guard_q == acm_pkg::CNT_W'(acm_pkg::MAX_NODES));
  assign c_last    = (c_q == acm_pkg::SYM_W'(acm_pkg::ALPHABET - 1));
  assign clr_low   = (clr_q < acm_pkg::GOTO_AW'(acm_pkg::MAX_NODES));
  assign sym_slot  = sym_q[acm_pkg::SYM_W-1:0];
  assign sum       = {1'b0, total_q} + (acm_pkg::TOTAL_W + 1)'(cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      acm_pkg::S_CLEAR: begin
        if (clr_q == '1) state_d = acm_pkg::S_IDLE;
      end
      acm_pkg::S_IDLE: begin
        if (accept) state_d = acm_pkg::S_DISP;
      end
      acm_pkg::S_DISP: begin
        state_d = acm_pkg::S_DONE;
        if (kind_q == acm_pkg::K_PAT_BYTE && !built_q && in_alpha) begin
          state_d = acm_pkg::S_INS_CHK;
        end else if (kind_q == acm_pkg::K_BUILD && !built_q) begin
          state_d = acm_pkg::S_ROOT_RD;
        end else if (kind_q == acm_pkg::K_TEXT && built_q && in_alpha) begin
          state_d = acm_pkg::S_T_GCHK;
        end
      end
      acm_pkg::S_INS_CHK:  state_d = acm_pkg::S_DONE;
      acm_pkg::S_ROOT_RD:  state_d = acm_pkg::S_ROOT_CHK;
      acm_pkg::S_ROOT_CHK: state_d = c_last ? acm_pkg::S_POP : acm_pkg::S_ROOT_RD;
      acm_pkg::S_POP:      state_d = (head_q == tail_q) ? acm_pkg::S_DONE : acm_pkg::S_POP_W;
      acm_pkg::S_POP_W:    state_d = acm_pkg::S_FAIL_W;
      acm_pkg::S_FAIL_W:   state_d = acm_pkg::S_CH_RD;
      acm_pkg::S_CH_RD:    state_d = acm_pkg::S_CH_CHK;
      acm_pkg::S_CH_CHK: begin
        if (g_valid) state_d = acm_pkg::S_S_CHK;
        else state_d = c_last ? acm_pkg::S_POP : acm_pkg::S_CH_RD;
      end
      acm_pkg::S_S_CHK: begin
        if (g_valid || guard_max) state_d = c_last ? acm_pkg::S_POP : acm_pkg::S_CH_RD;
        else state_d = acm_pkg::S_SF_W;
      end
      acm_pkg::S_SF_W: state_d = acm_pkg::S_S_CHK;
      acm_pkg::S_T_GCHK: begin
        state_d = (g_valid || guard_max) ? acm_pkg::S_T_CHAIN : acm_pkg::S_T_FW;
      end
      acm_pkg::S_T_FW: state_d = acm_pkg::S_T_GCHK;
      acm_pkg::S_T_CHAIN: begin
        state_d = (node_q == '0 || guard_max) ? acm_pkg::S_DONE : acm_pkg::S_T_CW;
      end
      acm_pkg::S_T_CW: state_d = acm_pkg::S_T_CHAIN;
      acm_pkg::S_DONE: begin
        if (load) state_d = acm_pkg::S_IDLE;
      end
      default: state_d = acm_pkg::S_CLEAR;
    endcase
  end

  // datapath registers
  always_comb begin
    clr_d    = clr_q;
    kind_d   = kind_q;
    sym_d    = sym_q;
    used_d   = used_q;
    insert_d = insert_q;
    search_d = search_q;
    total_d  = total_q;
    built_d  = built_q;
    c_d      = c_q;
    head_d   = head_q;
    tail_d   = tail_q;
    node_d   = node_q;
    fnode_d  = fnode_q;
    s_d      = s_q;
    child_d  = child_q;
    guard_d  = guard_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    case (state_q)
      acm_pkg::S_CLEAR: clr_d = clr_q + 1'b1;
      acm_pkg::S_IDLE: begin
        if (accept) begin
          kind_d   = req_i.kind;
          sym_d    = req_i.byte_value;
          status_d = acm_pkg::ST_OK;
          cnt_d    = '0;
        end
      end
      acm_pkg::S_DISP: begin
        case (kind_q)
          acm_pkg::K_PAT_BYTE: begin
            if (built_q) status_d = acm_pkg::ST_AFTER_BUILD;
          end
          acm_pkg::K_PAT_END: begin
            if (built_q) status_d = acm_pkg::ST_AFTER_BUILD;
            else insert_d = '0;
          end
          acm_pkg::K_BUILD: begin
            c_d    = '0;
            head_d = '0;
            tail_d = '0;
          end
          acm_pkg::K_TEXT: begin
            if (!built_q) status_d = acm_pkg::ST_BEFORE_BUILD;
            else if (!in_alpha) search_d = '0;
            s_d     = search_q;
            guard_d = '0;
          end
          acm_pkg::K_NEW_TEXT: begin
            search_d = '0;
            total_d  = '0;
          end
          default: ;
        endcase
      end
      acm_pkg::S_INS_CHK: begin
        if (g_valid) begin
          insert_d = g_node;
        end else if (used_q >= acm_pkg::CNT_W'(acm_pkg::MAX_NODES)) begin
          status_d = acm_pkg::ST_FULL;
        end else begin
          insert_d = used_q[acm_pkg::NODE_W-1:0];
          used_d   = used_q + 1'b1;
        end
      end
      acm_pkg::S_ROOT_CHK: begin
        if (g_valid) tail_d = tail_q + 1'b1;
        c_d = c_q + 1'b1;
      end
      acm_pkg::S_POP: begin
        if (head_q == tail_q) built_d = 1'b1;
        else head_d = head_q + 1'b1;
      end
      acm_pkg::S_POP_W: begin
        node_d = queue_rd_i;
        c_d    = '0;
      end
      acm_pkg::S_FAIL_W: fnode_d = fail_rd_i;
      acm_pkg::S_CH_CHK: begin
        if (g_valid) begin
          child_d = g_node;
          s_d     = fnode_q;
          guard_d = '0;
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      acm_pkg::S_S_CHK: begin
        if (g_valid || guard_max) begin
          tail_d = tail_q + 1'b1;
          c_d    = c_q + 1'b1;
        end
      end
      acm_pkg::S_SF_W: begin
        s_d     = fail_rd_i;
        guard_d = guard_q + 1'b1;
      end
      acm_pkg::S_T_GCHK: begin
        if (g_valid || guard_max) begin
          search_d = g_node;
          node_d   = g_node;
          guard_d  = '0;
        end
      end
      acm_pkg::S_T_FW: begin
        s_d     = fail_rd_i;
        guard_d = guard_q + 1'b1;
      end
      acm_pkg::S_T_CHAIN: begin
        if (node_q == '0 || guard_max) begin
          total_d = sum[acm_pkg::TOTAL_W] ? '1 : sum[acm_pkg::TOTAL_W-1:0];
        end
      end
      acm_pkg::S_T_CW: begin
        if (final_rd_i) cnt_d = cnt_q + 1'b1;
        node_d  = fail_rd_i;
        guard_d = guard_q + 1'b1;
      end
      default: ;
    endcase
  end

  // memory requests and handshake
  always_comb begin
    goto_req_o  = '0;
    fail_req_o  = '0;
    final_req_o = '0;
    queue_req_o = '0;
    req_i.ready = (state_q == acm_pkg::S_IDLE);
    case (state_q)
      acm_pkg::S_CLEAR: begin
        goto_req_o.we     = 1'b1;
        goto_req_o.waddr  = clr_q;
        fail_req_o.we     = clr_low;
        fail_req_o.waddr  = clr_q[acm_pkg::NODE_W-1:0];
        final_req_o.we    = clr_low;
        final_req_o.waddr = clr_q[acm_pkg::NODE_W-1:0];
      end
      acm_pkg::S_DISP: begin
        goto_req_o.raddr = (kind_q == acm_pkg::K_TEXT) ? {search_q, sym_slot}
                                                        : {insert_q, sym_slot};
        if (kind_q == acm_pkg::K_PAT_END && !built_q) begin
          final_req_o.we    = 1'b1;
          final_req_o.waddr = insert_q;
          final_req_o.wdata = 1'b1;
        end
      end
      acm_pkg::S_INS_CHK: begin
        if (!g_valid && used_q < acm_pkg::CNT_W'(acm_pkg::MAX_NODES)) begin
          goto_req_o.we    = 1'b1;
          goto_req_o.waddr = {insert_q, sym_slot};
          goto_req_o.wdata = {1'b1, used_q[acm_pkg::NODE_W-1:0]};
        end
      end
      acm_pkg::S_ROOT_RD: goto_req_o.raddr = {acm_pkg::NODE_W'(0), c_q};
      acm_pkg::S_ROOT_CHK: begin
        if (g_valid) begin
          fail_req_o.we     = 1'b1;
          fail_req_o.waddr  = g_node;
          queue_req_o.we    = 1'b1;
          queue_req_o.waddr = tail_q[acm_pkg::NODE_W-1:0];
          queue_req_o.wdata = g_node;
        end else begin
          // missing root transition loops back to the root
          goto_req_o.we    = 1'b1;
          goto_req_o.waddr = {acm_pkg::NODE_W'(0), c_q};
          goto_req_o.wdata = {1'b1, acm_pkg::NODE_W'(0)};
        end
      end
      acm_pkg::S_POP:    queue_req_o.raddr = head_q[acm_pkg::NODE_W-1:0];
      acm_pkg::S_POP_W:  fail_req_o.raddr = queue_rd_i;
      acm_pkg::S_CH_RD:  goto_req_o.raddr = {node_q, c_q};
      acm_pkg::S_CH_CHK: goto_req_o.raddr = {fnode_q, c_q};
      acm_pkg::S_S_CHK: begin
        if (g_valid || guard_max) begin
          fail_req_o.we     = 1'b1;
          fail_req_o.waddr  = child_q;
          fail_req_o.wdata  = g_node;
          queue_req_o.we    = 1'b1;
          queue_req_o.waddr = tail_q[acm_pkg::NODE_W-1:0];
          queue_req_o.wdata = child_q;
        end else begin
          fail_req_o.raddr = s_q;
        end
      end
      acm_pkg::S_SF_W:   goto_req_o.raddr = {fail_rd_i, c_q};
      acm_pkg::S_T_GCHK: fail_req_o.raddr = s_q;
      acm_pkg::S_T_FW:   goto_req_o.raddr = {fail_rd_i, sym_slot};
      acm_pkg::S_T_CHAIN: begin
        fail_req_o.raddr  = node_q;
        final_req_o.raddr = node_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= acm_pkg::S_CLEAR;
      clr_q       <= '0;
      used_q      <= acm_pkg::CNT_W'(1);
      insert_q    <= '0;
      search_q    <= '0;
      total_q     <= '0;
      built_q     <= 1'b0;
      c_q         <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      guard_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      used_q   <= used_d;
      insert_q <= insert_d;
      search_q <= search_d;
      total_q  <= total_d;
      built_q  <= built_d;
      c_q      <= c_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      guard_q  <= guard_d;
      cnt_q    <= cnt_d;
      if (load) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    sym_q    <= sym_d;
    node_q   <= node_d;
    fnode_q  <= fnode_d;
    s_q      <= s_d;
    child_q  <= child_d;
    status_q <= status_d;
    if (load) begin
      out_status_q <= status_q;
      out_here_q   <= (32'(cnt_q) > 32'(acm_pkg::HERE_MAX)) ? acm_pkg::HERE_W'(acm_pkg::HERE_MAX)
                                                            : acm_pkg::HERE_W'(cnt_q);
      out_total_q  <= total_q;
      out_node_q   <= (kind_q == acm_pkg::K_PAT_BYTE || kind_q == acm_pkg::K_PAT_END)
                      ? 10'(insert_q) : 10'(search_q);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.matches_here = out_here_q;
  assign rsp_o.match_total  = out_total_q;
  assign rsp_o.current_node = out_node_q;

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q != '0 && used_q <= acm_pkg::CNT_W'(acm_pkg::MAX_NODES))
    else $error("node count out of range");

  a_insert_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acm_pkg::CNT_W'(insert_q) < used_q)
    else $error("insert node not allocated");

  a_built_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    built_q |=> built_q)
    else $error("links built flag dropped");

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("bfs queue head passed tail");

endmodule
`default_nettype wire

// ===== design/aho_corasick_multi_pattern_matcher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Aho-Corasick multi-pattern byte matcher.
// req_i carries one request per item (kind, byte_value): pattern bytes grow the
// trie, pattern end marks a final node, build computes suffix links once,
// text bytes advance the search, start new text clears the search state.
// rsp_o returns exactly one result per request: status, matches_here,
// match_total and current_node.
// A text byte follows suffix links until a transition exists, then walks the
// output chain; build scans the root's transitions, then for each node in
// breadth-first order scans its transitions and follows suffix links for each
// child. All walks go through one read port on each table, so one request is
// in flight at a time and ready is low while it runs; ready returns in the
// cycle after the result is loaded.
// After reset a clearing pass (one transition entry per cycle) empties the
// transition table and suffix/final tables; no request
// is taken meanwhile. A stalled receiver holds the result in the output
// register; the next request is still accepted and waits only at its end.
module aho_corasick_multi_pattern_matcher_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  acm_req_if.sink   req_i,
  acm_rsp_if.source rsp_o
);

  acm_pkg::goto_req_t         goto_req;
  acm_pkg::node_req_t         fail_req;
  acm_pkg::flag_req_t         final_req;
  acm_pkg::node_req_t         queue_req;
  logic [acm_pkg::GOTO_W-1:0] goto_rd;
  logic [acm_pkg::NODE_W-1:0] fail_rd;
  logic                       final_rd;
  logic [acm_pkg::NODE_W-1:0] queue_rd;

  acm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .goto_req_o  (goto_req),
    .goto_rd_i   (goto_rd),
    .fail_req_o  (fail_req),
    .fail_rd_i   (fail_rd),
    .final_req_o (final_req),
    .final_rd_i  (final_rd),
    .queue_req_o (queue_req),
    .queue_rd_i  (queue_rd)
  );

  acm_ram #(.WIDTH(acm_pkg::GOTO_W), .DEPTH(acm_pkg::GOTO_DEPTH)) u_goto (
    .clk_i   (clk_i),
    .we_i    (goto_req.we),
    .waddr_i (goto_req.waddr),
    .wdata_i (goto_req.wdata),
    .raddr_i (goto_req.raddr),
    .rdata_o (goto_rd)
  );

  acm_ram #(.WIDTH(acm_pkg::NODE_W), .DEPTH(acm_pkg::MAX_NODES)) u_fail (
    .clk_i   (clk_i),
    .we_i    (fail_req.we),
    .waddr_i (fail_req.waddr),
    .wdata_i (fail_req.wdata),
    .raddr_i (fail_req.raddr),
    .rdata_o (fail_rd)
  );

  acm_ram #(.WIDTH(1), .DEPTH(acm_pkg::MAX_NODES)) u_final (
    .clk_i   (clk_i),
    .we_i    (final_req.we),
    .waddr_i (final_req.waddr),
    .wdata_i (final_req.wdata),
    .raddr_i (final_req.raddr),
    .rdata_o (final_rd)
  );

  acm_ram #(.WIDTH(acm_pkg::NODE_W), .DEPTH(acm_pkg::MAX_NODES)) u_queue (
    .clk_i   (clk_i),
    .we_i    (queue_req.we),
    .waddr_i (queue_req.waddr),
    .wdata_i (queue_req.wdata),
    .raddr_i (queue_req.raddr),
    .rdata_o (queue_rd)
  );

endmodule
`default_nettype wire
